// ===== rtl/core/dfe_pkg.sv =====
// Package for the DShot frame encoder: field widths, codes, reset values,
// payload structs and the frame checksum function. No dependencies.
`default_nettype none

package dfe_pkg;

  // Frame and field widths
  localparam int unsigned FRAME_BITS   = 16;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned THR_W        = 11;
  localparam int unsigned BIT_IDX_W    = 5;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  // Item selector codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_PACKET   = 2'd1;
  localparam logic [1:0] FUNC_THROTTLE = 2'd2;
  localparam logic [1:0] FUNC_RAW      = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BUSY      = 2'd1;
  localparam logic [1:0] STATUS_THR_RANGE = 2'd2;

  // Line phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BITS  = 2'd1;
  localparam logic [1:0] PH_PAUSE = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAUSE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THR_LOW    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THR_HIGH   = 3'd5;

  // Register reset values
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD = 16'd133;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 16'd89;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 16'd44;
  localparam logic [TICK_W-1:0] RST_PAUSE      = 16'd3800;
  localparam logic [THR_W-1:0]  RST_THR_LOW    = 11'd48;
  localparam logic [THR_W-1:0]  RST_THR_HIGH   = 11'd2047;

  typedef struct packed {
    logic [1:0]            func;
    logic [FRAME_BITS-1:0] value;
    logic                  telemetry_request;
  } req_item_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic [1:0] status;
    logic       frame_done;
  } rsp_item_t;

  // Value, telemetry bit, then the XOR of the three nibbles of that 12-bit word.
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [THR_W-1:0] payload,
                                                        input logic tel);
    logic [11:0] w;
    logic [3:0]  sum;
    w   = {payload, tel};
    sum = w[3:0] ^ w[7:4] ^ w[11:8];
    return {w, sum};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfe_stream_if.sv =====
// Valid/ready channel carrying one word of a payload type given as a parameter.
// Depends on nothing; the payload structs come from dfe_pkg at instantiation.
`default_nettype none

interface dfe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dshot_frame_encoder.sv =====
// DShot frame encoder top level: register bank, frame state and result register.
// Depends on dfe_pkg and dfe_stream_if.
//
//   channel | dir | payload                                      | handshake
//   req     | in  | func, value, telemetry_request               | valid/ready
//   rsp     | out | line_level, busy_res, status, frame_done     | valid/ready
//   cfg     | in  | cfg_index, cfg_data                          | cfg_wr_en only
//
// The frame state is updated and the result is registered at the same edge, so a
// new word can be taken every cycle while rsp keeps taking the results.
// The result is held in a single result register; req stalls only while
// that register holds a word that rsp has not taken.
// Reset (rst, synchronous) loads the register defaults and idles the line.
`default_nettype none

module dshot_frame_encoder
  import dfe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  dfe_stream_if.sink                  req,
  dfe_stream_if.source                rsp,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [TICK_W-1:0] bit_period_ticks;
  logic [TICK_W-1:0] one_high_ticks;
  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] pause_ticks;
  logic [THR_W-1:0]  throttle_low;
  logic [THR_W-1:0]  throttle_high;

  // Frame state
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [BIT_IDX_W-1:0]  bit_index, bit_index_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [1:0]            phase, phase_next;

  // Result register
  logic      rsp_valid;
  rsp_item_t rsp_data;
  rsp_item_t result;

  logic        req_fire;
  logic [1:0]  func;
  logic        is_tick;
  logic        thr_bad;
  logic [TICK_W:0]      tick_inc;
  logic [BIT_IDX_W-1:0] bit_index_inc;
  logic        bit_end;
  logic        pause_end;
  logic        level_now;

  assign req.ready  = !rsp_valid || rsp.ready;
  assign req_fire   = req.valid && req.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.data   = rsp_data;

  assign func    = req.data.func;
  assign is_tick = (func == FUNC_TICK);

  // Line level for a given state: high while the count is below the bit's high time.
  function automatic logic line_of(input logic [1:0] ph, input logic [FRAME_BITS-1:0] sh,
                                   input logic [TICK_W-1:0] cnt,
                                   input logic [TICK_W-1:0] one_hi,
                                   input logic [TICK_W-1:0] zero_hi);
    logic [TICK_W-1:0] hi;
    hi = sh[FRAME_BITS-1] ? one_hi : zero_hi;
    return (ph == PH_BITS) && (cnt < hi);
  endfunction

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ticks <= RST_BIT_PERIOD;
      one_high_ticks   <= RST_ONE_HIGH;
      zero_high_ticks  <= RST_ZERO_HIGH;
      pause_ticks      <= RST_PAUSE;
      throttle_low     <= RST_THR_LOW;
      throttle_high    <= RST_THR_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BIT_PERIOD: bit_period_ticks <= cfg_data;
        REG_ONE_HIGH:   one_high_ticks   <= cfg_data;
        REG_ZERO_HIGH:  zero_high_ticks  <= cfg_data;
        REG_PAUSE:      pause_ticks      <= cfg_data;
        REG_THR_LOW:    throttle_low     <= cfg_data[THR_W-1:0];
        REG_THR_HIGH:   throttle_high    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole 16-bit value is range checked against the 11-bit limits.
  assign thr_bad = (func == FUNC_THROTTLE) &&
                   ((req.data.value < {5'd0, throttle_low}) ||
                    (req.data.value > {5'd0, throttle_high}));

  assign tick_inc      = {1'b0, tick_count} + {{TICK_W{1'b0}}, 1'b1};
  assign bit_index_inc = bit_index + {{(BIT_IDX_W-1){1'b0}}, 1'b1};
  assign bit_end       = tick_inc >= {1'b0, bit_period_ticks};
  assign pause_end     = tick_inc >= {1'b0, pause_ticks};

  // Next frame state and the result word.
  always_comb begin
    frame_shift_next  = frame_shift;
    bit_index_next    = bit_index;
    tick_count_next   = tick_count;
    phase_next        = phase;
    result.status     = STATUS_OK;
    result.frame_done = 1'b0;
    if (is_tick) begin
      case (phase)
        PH_BITS: begin
          if (bit_end) begin
            tick_count_next  = '0;
            frame_shift_next = {frame_shift[FRAME_BITS-2:0], 1'b0};
            bit_index_next   = bit_index_inc;
            if (bit_index_inc >= BIT_IDX_W'(FRAME_BITS)) begin
              if (pause_ticks == '0) begin
                phase_next        = PH_IDLE;
                result.frame_done = 1'b1;
              end else begin
                phase_next = PH_PAUSE;
              end
            end
          end else begin
            tick_count_next = tick_inc[TICK_W-1:0];
          end
        end
        PH_PAUSE: begin
          if (pause_end) begin
            tick_count_next   = '0;
            phase_next        = PH_IDLE;
            result.frame_done = 1'b1;
          end else begin
            tick_count_next = tick_inc[TICK_W-1:0];
          end
        end
        default: ;
      endcase
    end else if (thr_bad) begin
      result.status = STATUS_THR_RANGE;
    end else if (phase != PH_IDLE) begin
      result.status = STATUS_BUSY;
    end else begin
      case (func)
        FUNC_PACKET:   frame_shift_next = build_frame(req.data.value[THR_W-1:0],
                                                      req.data.telemetry_request);
        FUNC_THROTTLE: frame_shift_next = build_frame(req.data.value[THR_W-1:0], 1'b0);
        default:       frame_shift_next = req.data.value;
      endcase
      bit_index_next  = '0;
      tick_count_next = '0;
      phase_next      = PH_BITS;
    end
    // A load shows the level that the next tick will start from.
    result.line_level = is_tick ? level_now
                                : line_of(phase_next, frame_shift_next, tick_count_next,
                                          one_high_ticks, zero_high_ticks);
    result.busy_res   = (phase_next != PH_IDLE);
  end

  // A tick shows the level before it advances.
  assign level_now   = line_of(phase, frame_shift, tick_count,
                               one_high_ticks, zero_high_ticks);

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bit_index   <= '0;
      tick_count  <= '0;
      phase       <= PH_IDLE;
    end else if (req_fire) begin
      frame_shift <= frame_shift_next;
      bit_index   <= bit_index_next;
      tick_count  <= tick_count_next;
      phase       <= phase_next;
    end
  end

  // Result register: filled by an accepted word, emptied when rsp takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_data <= result;
    end
  end

  // A finished frame always leaves the line idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.frame_done |-> !rsp_data.busy_res)
    else $error("frame_done reported while still busy");

  // The bit counter never runs past the frame while bits are sent.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BITS |-> bit_index < BIT_IDX_W'(FRAME_BITS))
    else $error("bit_index beyond frame while sending");

  // An idle line always has a cleared tick count.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0)
    else $error("tick_count not cleared while idle");

  // A valid load taken while idle starts sending bits.
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    req_fire && !is_tick && !thr_bad && phase == PH_IDLE |=> phase == PH_BITS)
    else $error("accepted load did not start a frame");

endmodule

`default_nettype wire

// ===== sim/tb_dshot_frame_encoder.sv =====
// Self-checking testbench for the DShot frame encoder: directed table, then random phases.
// Depends on dfe_pkg and dfe_stream_if from the RTL and on the dshot_frame_encoder top level.
`timescale 1ns / 1ps

module tb_dshot_frame_encoder;
  import dfe_pkg::*;

  // Register indexes with no register behind them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int unsigned ITEM_TARGET    = 1450;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_REG,
    ROW_DRAIN
  } row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    req_item_t                 word;
    logic [CFG_INDEX_W-1:0]    reg_idx;
    bit                        fixed;
    rsp_item_t                 fixed_rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dfe_stream_if #(.payload_t(req_item_t)) req_ch ();
  dfe_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

  dshot_frame_encoder DUT (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers and frame state of the encoder as this bench predicts them.
  logic [TICK_W-1:0]    cfg_period, cfg_one, cfg_zero, cfg_pause;
  logic [THR_W-1:0]     cfg_thr_lo, cfg_thr_hi;
  logic [FRAME_BITS-1:0] frm_shift;
  logic [BIT_IDX_W-1:0]  bit_no;
  logic [TICK_W-1:0]     tick_cnt;
  logic [1:0]            line_phase;

  rsp_item_t line_results_q[$];
  stim_row_t stim_table[$];

  bit failed = 1'b0;
  bit steady_mode = 1'b0;
  bit rx_hold_request = 1'b0;
  int unsigned sent_items = 0;

  // Line level shown by the next tick at the current waveform position.
  function automatic logic line_level_now();
    logic [TICK_W-1:0] high_time;
    if (line_phase != PH_BITS) return 1'b0;
    high_time = frm_shift[FRAME_BITS-1] ? cfg_one : cfg_zero;
    return tick_cnt < high_time;
  endfunction

  // Advances the predicted encoder by one accepted word and returns the result word.
  task automatic advance_encoder(input req_item_t w, output rsp_item_t r);
    logic [11:0]           tw;
    logic                  lvl;
    logic                  done;
    logic [1:0]            st;
    lvl  = 1'b0;
    done = 1'b0;
    st   = STATUS_OK;
    if (w.func == FUNC_TICK) begin
      lvl = line_level_now();
      if (line_phase == PH_BITS) begin
        if (({1'b0, tick_cnt} + 17'd1) >= {1'b0, cfg_period}) begin
          tick_cnt  = '0;
          frm_shift = frm_shift << 1;
          bit_no    = bit_no + 1'b1;
          if (bit_no >= FRAME_BITS) begin
            if (cfg_pause == '0) begin
              line_phase = PH_IDLE;
              done = 1'b1;
            end else begin
              line_phase = PH_PAUSE;
            end
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end else if (line_phase == PH_PAUSE) begin
        if (({1'b0, tick_cnt} + 17'd1) >= {1'b0, cfg_pause}) begin
          tick_cnt   = '0;
          line_phase = PH_IDLE;
          done = 1'b1;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
    end else begin
      // The range check on throttle words comes ahead of the busy check.
      if (w.func == FUNC_THROTTLE &&
          (w.value < {5'd0, cfg_thr_lo} || w.value > {5'd0, cfg_thr_hi})) begin
        st = STATUS_THR_RANGE;
      end else if (line_phase != PH_IDLE) begin
        st = STATUS_BUSY;
      end else begin
        tw = {w.value[10:0], (w.func == FUNC_PACKET) ? w.telemetry_request : 1'b0};
        frm_shift  = (w.func == FUNC_RAW) ? w.value : {tw, tw[3:0] ^ tw[7:4] ^ tw[11:8]};
        bit_no     = '0;
        tick_cnt   = '0;
        line_phase = PH_BITS;
      end
      lvl = line_level_now();
    end
    r = {lvl, line_phase != PH_IDLE, st, done};
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random word: loads come often while the line is idle, rarely while it is busy.
  function automatic req_item_t next_random_word();
    req_item_t   w;
    int unsigned chance;
    w.value = 16'($urandom);
    w.telemetry_request = 1'($urandom_range(0, 1));
    w.func = FUNC_TICK;
    chance = (line_phase == PH_IDLE) ? 60 : 6;
    if ($urandom_range(0, 99) < chance) begin
      case ($urandom_range(0, 3))
        0: w.func = FUNC_PACKET;
        3: w.func = FUNC_RAW;
        default: begin
          w.func = FUNC_THROTTLE;
          case ($urandom_range(0, 5))
            0: w.value = {5'd0, cfg_thr_lo} - 16'd1;
            1: w.value = {5'd0, cfg_thr_lo};
            2: w.value = {5'd0, cfg_thr_hi};
            3: w.value = {5'd0, cfg_thr_hi} + 16'd1;
            4: w.value = {5'd0, w.value[10:0]};
            default: ;
          endcase
        end
      endcase
    end
    return w;
  endfunction

  // Offers one word, waits for it to be taken and records what should come back.
  task automatic offer_word(input req_item_t w, input bit use_fixed, input rsp_item_t fixed_rsp);
    rsp_item_t   predicted;
    int unsigned gap;
    req_ch.data  <= w;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sent_items++;
    advance_encoder(w, predicted);
    line_results_q.push_back(use_fixed ? fixed_rsp : predicted);
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic release_req();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Ticks the line until the frame and its pause are over.
  task automatic finish_frame();
    req_item_t w;
    while (line_phase != PH_IDLE) begin
      w.func = FUNC_TICK;
      w.value = 16'($urandom);
      w.telemetry_request = 1'($urandom_range(0, 1));
      offer_word(w, 1'b0, '0);
    end
  endtask

  // Writes one register once every result word has come back.
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    release_req();
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_BIT_PERIOD: cfg_period = data;
      REG_ONE_HIGH:   cfg_one    = data;
      REG_ZERO_HIGH:  cfg_zero   = data;
      REG_PAUSE:      cfg_pause  = data;
      REG_THR_LOW:    cfg_thr_lo = data[THR_W-1:0];
      REG_THR_HIGH:   cfg_thr_hi = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Writes the whole bank; throttle words carry junk above bit 10, spare indexes get junk.
  task automatic program_set(input logic [15:0] p, input logic [15:0] o, input logic [15:0] z,
                             input logic [15:0] pa, input logic [10:0] lo, input logic [10:0] hi);
    logic [15:0] lo_word, hi_word;
    lo_word = 16'($urandom);
    hi_word = 16'($urandom);
    lo_word[10:0] = lo;
    hi_word[10:0] = hi;
    program_reg(REG_BIT_PERIOD, p);
    program_reg(REG_ONE_HIGH, o);
    program_reg(REG_ZERO_HIGH, z);
    program_reg(REG_PAUSE, pa);
    program_reg(REG_THR_LOW, lo_word);
    program_reg(REG_THR_HIGH, hi_word);
    program_reg(REG_SPARE_A, 16'($urandom));
    program_reg(REG_SPARE_B, 16'($urandom));
  endtask

  task automatic add_row(input row_kind_t k, input logic [1:0] f, input logic [15:0] v,
                         input logic t, input logic [CFG_INDEX_W-1:0] idx, input bit fx,
                         input rsp_item_t e);
    stim_row_t row;
    row.kind = k;
    row.word.func = f;
    row.word.value = v;
    row.word.telemetry_request = t;
    row.reg_idx = idx;
    row.fixed = fx;
    row.fixed_rsp = e;
    stim_table.push_back(row);
  endtask

  // Result sink: random bursts and gaps, ready in steady phases, long hold on request that overrides both.
  initial begin : result_sink
    int unsigned hold_left, burst_left, gap_left;
    bit          hold_started;
    hold_left = 0;
    burst_left = 0;
    gap_left = 0;
    hold_started = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (steady_mode) begin
        rsp_ch.ready <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        rsp_ch.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = pick_gap();
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Each result word is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    rsp_item_t want, got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (line_results_q.size() == 0) begin
        $error("result word with nothing expected: %b", got);
        failed = 1'b1;
      end else begin
        want = line_results_q.pop_front();
        if (got.line_level !== want.line_level) begin
          $error("line_level: expected %0d, actual %0d", want.line_level, got.line_level);
          failed = 1'b1;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_no;
    logic [15:0] p, o, z, pa;
    logic [10:0] lo, hi;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;

    // Predicted state after reset.
    cfg_period = RST_BIT_PERIOD;
    cfg_one    = RST_ONE_HIGH;
    cfg_zero   = RST_ZERO_HIGH;
    cfg_pause  = RST_PAUSE;
    cfg_thr_lo = RST_THR_LOW;
    cfg_thr_hi = RST_THR_HIGH;
    frm_shift  = '0;
    bit_no     = '0;
    tick_cnt   = '0;
    line_phase = PH_IDLE;

    // Reset defaults: idle tick, range rejects, a frame with busy rejects on top.
    add_row(ROW_WORD, FUNC_TICK, 16'h0000, 1'b0, '0, 1'b1, {1'b0, 1'b0, STATUS_OK, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd47, 1'b0, '0, 1'b1,
            {1'b0, 1'b0, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd2048, 1'b1, '0, 1'b1,
            {1'b0, 1'b0, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'hffff, 1'b0, '0, 1'b1,
            {1'b0, 1'b0, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_WORD, FUNC_PACKET, 16'hffff, 1'b1, '0, 1'b0, '0);
    add_row(ROW_WORD, FUNC_RAW, 16'h0000, 1'b0, '0, 1'b1, {1'b1, 1'b1, STATUS_BUSY, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd0, 1'b0, '0, 1'b1,
            {1'b1, 1'b1, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd48, 1'b0, '0, 1'b1, {1'b1, 1'b1, STATUS_BUSY, 1'b0});
    // Shortest period the bench uses, high times at both ends and no pause; the frame in flight is
    // shortened by these writes and then run out.
    add_row(ROW_REG, FUNC_TICK, 16'd2, 1'b0, REG_BIT_PERIOD, 1'b0, '0);
    add_row(ROW_REG, FUNC_TICK, 16'hffff, 1'b0, REG_ONE_HIGH, 1'b0, '0);
    add_row(ROW_REG, FUNC_TICK, 16'd1, 1'b0, REG_ZERO_HIGH, 1'b0, '0);
    add_row(ROW_REG, FUNC_TICK, 16'd0, 1'b0, REG_PAUSE, 1'b0, '0);
    add_row(ROW_DRAIN, FUNC_TICK, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ROW_WORD, FUNC_RAW, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ROW_DRAIN, FUNC_TICK, 16'h0000, 1'b0, '0, 1'b0, '0);
    add_row(ROW_WORD, FUNC_RAW, 16'hffff, 1'b1, '0, 1'b0, '0);
    add_row(ROW_DRAIN, FUNC_TICK, 16'h0000, 1'b0, '0, 1'b0, '0);
    // An empty throttle range turns every throttle word away.
    add_row(ROW_REG, FUNC_TICK, 16'd2047, 1'b0, REG_THR_LOW, 1'b0, '0);
    add_row(ROW_REG, FUNC_TICK, 16'd0, 1'b0, REG_THR_HIGH, 1'b0, '0);
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd2047, 1'b0, '0, 1'b1,
            {1'b0, 1'b0, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd0, 1'b1, '0, 1'b1,
            {1'b0, 1'b0, STATUS_THR_RANGE, 1'b0});
    add_row(ROW_REG, FUNC_TICK, 16'd0, 1'b0, REG_THR_LOW, 1'b0, '0);
    add_row(ROW_REG, FUNC_TICK, 16'd2047, 1'b0, REG_THR_HIGH, 1'b0, '0);
    add_row(ROW_WORD, FUNC_THROTTLE, 16'd0, 1'b1, '0, 1'b0, '0);
    add_row(ROW_DRAIN, FUNC_TICK, 16'h0000, 1'b0, '0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_WORD: offer_word(stim_table[i].word, stim_table[i].fixed, stim_table[i].fixed_rsp);
        ROW_REG:  program_reg(stim_table[i].reg_idx, stim_table[i].word.value);
        default:  finish_frame();
      endcase
    end

    // Random phases: a register setting, a run of random words, then the frame is run out.
    phase_no = 0;
    while (sent_items + PHASE_ITEMS <= ITEM_TARGET) begin
      steady_mode = 1'b0;
      case (phase_no)
        0: program_set(16'd2, 16'd1, 16'd1, 16'd0, 11'd0, 11'd2047);
        1: program_set(16'd3, 16'hffff, 16'd2, 16'd1, 11'd100, 11'd200);
        2: program_set(16'd4, 16'd2, 16'd4, 16'd3, 11'd0, 11'd2047);
        3: program_set(16'd2, 16'd2, 16'd1, 16'd40, 11'd2047, 11'd2047);
        4: program_set(16'd12, 16'd8, 16'd4, 16'd20, 11'd0, 11'd0);
        default: begin
          p  = 16'($urandom_range(2, 8));
          o  = 16'($urandom_range(1, p + 1));
          z  = 16'($urandom_range(1, p + 1));
          pa = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
          lo = 11'($urandom_range(0, 1500));
          hi = 11'($urandom_range(lo, 2047));
          if ($urandom_range(0, 5) == 0) program_set(p, o, z, pa, hi, lo);
          else program_set(p, o, z, pa, lo, hi);
        end
      endcase
      if (phase_no % 4 == 3) steady_mode = 1'b1;
      // Long hold-off on the result side while words keep coming, so the input stalls.
      if (phase_no == 2) begin
        steady_mode = 1'b1;
        rx_hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) offer_word(next_random_word(), 1'b0, '0);
      finish_frame();
      phase_no++;
    end

    release_req();
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dfe_pkg.sv
rtl/core/dfe_stream_if.sv
rtl/core/dshot_frame_encoder.sv
sim/tb_dshot_frame_encoder.sv
